[src/spdc_pkg.sv]
// shared constants, codes and types of the speed controller
`default_nettype none

package spdc_pkg;

    // default formats
    localparam int FRACTION_BITS_DEF = 12;
    localparam int TICK_BITS_DEF     = 32;

    // feedback factor is always Q0.12
    localparam int ALPHA_BITS = 12;

    // register widths
    localparam int REF_W   = 16;
    localparam int KP_W    = 16;
    localparam int ALPHA_W = 12;
    localparam int LIM_W   = 15;
    localparam int DT_W    = 16;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_REF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME = 3'd4;

    // reset value of the dead time length
    localparam logic [DT_W-1:0] DEAD_TIME_RESET = 16'd100;
    localparam logic [ALPHA_W-1:0] FB_FACTOR_RESET = 12'd256;

    // held drive direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    // bridge mode codes
    typedef enum logic [1:0] {
        MODE_COAST = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_REV   = 2'd2,
        MODE_BRAKE = 2'd3
    } t_mode;

    // configuration as seen by the datapath
    typedef struct packed {
        logic signed [REF_W-1:0] speed_reference;
        logic [KP_W-1:0]         proportional_gain;
        logic [ALPHA_W-1:0]      feedback_factor;
        logic [LIM_W-1:0]        command_limit;
        logic [DT_W-1:0]         dead_time_ticks;
    } t_cfg;

endpackage

`default_nettype wire

[src/spdc_if.sv]
// word channels: speed samples in, bridge commands out
`default_nettype none

interface spdc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured_speed;
    logic [31:0]        tick_now;

    modport source (output valid, output measured_speed, output tick_now, input ready);
    modport sink   (input valid, input measured_speed, input tick_now, output ready);
endinterface

interface spdc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_command;
    logic [1:0]         bridge_mode;
    logic               bridge_pin_a;
    logic               bridge_pin_b;

    modport source (output valid, output drive_command, output bridge_mode,
                    output bridge_pin_a, output bridge_pin_b, input ready);
    modport sink   (input valid, input drive_command, input bridge_mode,
                    input bridge_pin_a, input bridge_pin_b, output ready);
endinterface

`default_nettype wire

[src/spdc_cfg.sv]
// configuration registers behind the apb-style port
`default_nettype none

module spdc_cfg #(
    parameter int FRACTION_BITS = spdc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [spdc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [spdc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [spdc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output spdc_pkg::t_cfg                         o_cfg
);

    // reset values follow the fraction format
    localparam int RefRaw   = 3 << FRACTION_BITS;
    localparam int RefReset = (RefRaw > 32767) ? 32767 : RefRaw;
    localparam int OneReset = 1 << FRACTION_BITS;

    logic [spdc_pkg::CFG_IDX_W-1:0] idx;
    logic                           wr_en;
    spdc_pkg::t_cfg                 r_cfg;

    assign idx    = paddr[spdc_pkg::CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_reference   <= spdc_pkg::REF_W'(RefReset);
            r_cfg.proportional_gain <= spdc_pkg::KP_W'(OneReset);
            r_cfg.feedback_factor   <= spdc_pkg::FB_FACTOR_RESET;
            r_cfg.command_limit     <= spdc_pkg::LIM_W'(OneReset);
            r_cfg.dead_time_ticks   <= spdc_pkg::DEAD_TIME_RESET;
        end else if (wr_en) begin
            case (idx)
                spdc_pkg::REG_SPEED_REF: begin
                    r_cfg.speed_reference <= pwdata[spdc_pkg::REF_W-1:0];
                end
                spdc_pkg::REG_PROP_GAIN: begin
                    r_cfg.proportional_gain <= pwdata[spdc_pkg::KP_W-1:0];
                end
                spdc_pkg::REG_FB_FACTOR: begin
                    r_cfg.feedback_factor <= pwdata[spdc_pkg::ALPHA_W-1:0];
                end
                spdc_pkg::REG_CMD_LIMIT: begin
                    r_cfg.command_limit <= pwdata[spdc_pkg::LIM_W-1:0];
                end
                spdc_pkg::REG_DEAD_TIME: begin
                    r_cfg.dead_time_ticks <= pwdata[spdc_pkg::DT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        case (idx)
            spdc_pkg::REG_SPEED_REF: prdata = 32'({r_cfg.speed_reference});
            spdc_pkg::REG_PROP_GAIN: prdata = 32'(r_cfg.proportional_gain);
            spdc_pkg::REG_FB_FACTOR: prdata = 32'(r_cfg.feedback_factor);
            spdc_pkg::REG_CMD_LIMIT: prdata = 32'(r_cfg.command_limit);
            spdc_pkg::REG_DEAD_TIME: prdata = 32'(r_cfg.dead_time_ticks);
            default:                 prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[src/spdc_core.sv]
// sample register, control law, brake and dead time logic, result register
`default_nettype none

module spdc_core #(
    parameter int FRACTION_BITS = spdc_pkg::FRACTION_BITS_DEF,
    parameter int TICK_BITS     = spdc_pkg::TICK_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire spdc_pkg::t_cfg i_cfg,
    spdc_sample_if.sink         i_sample,
    spdc_result_if.source       o_result
);

    localparam int ACC_W   = 48;
    localparam int SHIFT   = FRACTION_BITS + spdc_pkg::ALPHA_BITS;

    // input stage
    logic                 r_in_valid;
    logic signed [15:0]   r_speed;
    logic [TICK_BITS-1:0] r_tick;
    logic [TICK_BITS+31:0] tick_ext;

    // controller state
    logic signed [15:0]   r_last;
    spdc_pkg::t_dir       r_dir;
    logic [TICK_BITS-1:0] r_dead_end;

    // result stage
    logic                 r_out_valid;
    logic signed [15:0]   r_cmd;
    spdc_pkg::t_mode      r_mode;

    logic advance;
    logic fire;

    logic signed [16:0]      err;
    logic signed [33:0]      p_term;
    logic signed [28:0]      q_term;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] lim_s;
    logic signed [ACC_W-1:0] clamped;
    logic signed [15:0]      cmd;
    logic [16:0]             mag;
    logic                    brake;
    logic                    in_dead;
    spdc_pkg::t_dir          req;
    logic [TICK_BITS+15:0]   dt_ext;
    logic [TICK_BITS-1:0]    dead_end_new;

    spdc_pkg::t_dir          n_dir;
    logic signed [15:0]      n_cmd;
    logic [TICK_BITS-1:0]    n_dead_end;
    spdc_pkg::t_mode         n_mode;

    // handshake: result register frees when taken
    assign advance        = !r_out_valid || o_result.ready;
    assign fire           = r_in_valid && advance;
    assign i_sample.ready = !r_in_valid || advance;

    assign tick_ext = {{TICK_BITS{1'b0}}, i_sample.tick_now};

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_speed <= i_sample.measured_speed;
            r_tick  <= tick_ext[TICK_BITS-1:0];
        end
    end

    // control law: kp*err + alpha*previous, rounded half up
    assign err    = 17'(i_cfg.speed_reference) - 17'(r_speed);
    assign p_term = $signed({1'b0, i_cfg.proportional_gain}) * err;
    assign q_term = $signed({1'b0, i_cfg.feedback_factor}) * r_last;
    assign acc    = (ACC_W'(p_term) <<< spdc_pkg::ALPHA_BITS)
                  + (ACC_W'(q_term) <<< FRACTION_BITS)
                  + (ACC_W'(1) <<< (SHIFT - 1));
    assign rounded = acc >>> SHIFT;

    // saturation to the limit
    assign lim_s = $signed(ACC_W'({1'b0, i_cfg.command_limit}));
    always_comb begin
        if (rounded > lim_s) begin
            clamped = lim_s;
        end else if (rounded < -lim_s) begin
            clamped = -lim_s;
        end else begin
            clamped = rounded;
        end
    end
    assign cmd = clamped[15:0];
    assign mag = cmd[15] ? -17'(cmd) : 17'(cmd);

    // brake on a large command against the previous sign
    assign brake = ({mag, 1'b0} >= 18'(i_cfg.command_limit)) && (cmd[15] != r_last[15]);

    // requested direction, zero asks for none
    always_comb begin
        if (cmd[15]) begin
            req = spdc_pkg::DIR_REV;
        end else if (cmd != 16'sd0) begin
            req = spdc_pkg::DIR_FWD;
        end else begin
            req = spdc_pkg::DIR_NONE;
        end
    end

    assign in_dead      = r_tick < r_dead_end;
    assign dt_ext       = {{TICK_BITS{1'b0}}, i_cfg.dead_time_ticks};
    assign dead_end_new = r_tick + dt_ext[TICK_BITS-1:0];

    // dead time and reversal handling
    always_comb begin
        n_dir      = r_dir;
        n_cmd      = cmd;
        n_dead_end = r_dead_end;
        if (brake) begin
            n_cmd = cmd;
        end else if (in_dead) begin
            n_cmd = 16'sd0;
        end else if (req != spdc_pkg::DIR_NONE && r_dir != spdc_pkg::DIR_NONE
                     && req != r_dir) begin
            n_dir      = spdc_pkg::DIR_NONE;
            n_cmd      = 16'sd0;
            n_dead_end = dead_end_new;
        end else if (req != spdc_pkg::DIR_NONE) begin
            n_dir = req;
        end
    end

    // bridge mode from brake or held direction
    always_comb begin
        if (brake) begin
            n_mode = spdc_pkg::MODE_BRAKE;
        end else begin
            case (n_dir)
                spdc_pkg::DIR_FWD: n_mode = spdc_pkg::MODE_FWD;
                spdc_pkg::DIR_REV: n_mode = spdc_pkg::MODE_REV;
                default:           n_mode = spdc_pkg::MODE_COAST;
            endcase
        end
    end

    // state update once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_dir      <= spdc_pkg::DIR_NONE;
            r_dead_end <= '0;
        end else if (fire) begin
            r_last     <= n_cmd;
            r_dir      <= n_dir;
            r_dead_end <= n_dead_end;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cmd  <= n_cmd;
            r_mode <= n_mode;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.drive_command = r_cmd;
    assign o_result.bridge_mode   = r_mode;
    assign o_result.bridge_pin_a  = (r_mode == spdc_pkg::MODE_FWD)
                                 || (r_mode == spdc_pkg::MODE_BRAKE);
    assign o_result.bridge_pin_b  = (r_mode == spdc_pkg::MODE_REV)
                                 || (r_mode == spdc_pkg::MODE_BRAKE);

endmodule

`default_nettype wire

[src/speed_controller_with_reverse_deadtime.sv]
// speed controller with h-bridge reverse dead time, top level
// a word in the input register moves on to the result register when that is free
// one word per cycle unless stalled; control law and state update sit in one stage
// a result waiting at the output does not block the input register from filling
// reset (synchronous, active low) empties both stages, clears command, direction
// and dead time end, and loads the configuration registers with their defaults
`default_nettype none

module speed_controller_with_reverse_deadtime #(
    parameter int FRACTION_BITS = spdc_pkg::FRACTION_BITS_DEF,
    parameter int TICK_BITS     = spdc_pkg::TICK_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    spdc_sample_if.sink                           i_sample,
    spdc_result_if.source                         o_result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [spdc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [spdc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [spdc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    spdc_pkg::t_cfg cfg;

    // configuration registers
    spdc_cfg #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // controller datapath
    spdc_core #(
        .FRACTION_BITS (FRACTION_BITS),
        .TICK_BITS     (TICK_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_sample (i_sample),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[src/spdc_checker.sv]
// port-level checks on the speed controller results, bound to the top level
`default_nettype none

module spdc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [15:0] i_cmd,
    input wire logic [1:0]  i_mode,
    input wire logic        i_pin_a,
    input wire logic        i_pin_b
);

    // a stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_cmd) && $stable(i_mode))
        else $error("stalled result word changed");

    // both pins high exactly in brake
    a_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_pin_a && i_pin_b) == (i_mode == spdc_pkg::MODE_BRAKE)))
        else $error("bridge pins disagree with brake mode");

    // coast drives no command
    a_coast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_mode == spdc_pkg::MODE_COAST) |-> (i_cmd == 16'd0))
        else $error("non-zero command while coasting");

    // command never opposes the held direction
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !((i_mode == spdc_pkg::MODE_FWD) && i_cmd[15])
                 && !((i_mode == spdc_pkg::MODE_REV) && !i_cmd[15] && (i_cmd != 16'd0)))
        else $error("command sign against bridge direction");

    // saturation keeps the most negative code away
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_cmd != 16'h8000))
        else $error("command outside saturation range");

endmodule

bind speed_controller_with_reverse_deadtime spdc_checker u_spdc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_cmd   (o_result.drive_command),
    .i_mode  (o_result.bridge_mode),
    .i_pin_a (o_result.bridge_pin_a),
    .i_pin_b (o_result.bridge_pin_b)
);

`default_nettype wire
